### sv/raru_pkg.sv
// Shared types and constants for the rational arithmetic reduce unit.
// Used by raru_div and rational_arith_reduce_unit.
`timescale 1ns / 1ps
`default_nettype none
package raru_pkg;
	localparam int OP_W  = 32;         // operand width
	localparam int MAG_W = 2 * OP_W;   // product and sum magnitude width
	localparam int REM_W = MAG_W + 1;  // partial remainder width in the divider
	localparam int CNT_W = $clog2(MAG_W + 1);
	localparam int K_W   = $clog2(MAG_W);

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_RED = 3'd4;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZDEN = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_D,
		ST_COMB,
		ST_GCD,
		ST_DIVN_GO,
		ST_DIVN,
		ST_DIVD_GO,
		ST_DIVD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] dividend;
		logic [MAG_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] quot;
	} div_rsp_t;
endpackage
`default_nettype wire

### sv/raru_cell.sv
// One bit of the divider's partial remainder: shift in from the lower
// neighbor, subtract the divisor bit with a borrow chain. Uses raru_pkg none.
`timescale 1ns / 1ps
`default_nettype none
module raru_cell (
	input  wire logic clk,
	input  wire logic clear,
	input  wire logic step,
	input  wire logic s_in,
	input  wire logic d_bit,
	input  wire logic b_in,
	input  wire logic take,
	output logic      r,
	output logic      b_out
);
	logic diff;
	logic r_q;

	// subtract one bit
	assign diff  = s_in ^ d_bit ^ b_in;
	assign b_out = (~s_in & d_bit) | (~(s_in ^ d_bit) & b_in);
	assign r     = r_q;

	// hold the remainder bit
	always_ff @(posedge clk) begin
		if (clear) begin
			r_q <= 1'b0;
		end else if (step) begin
			r_q <= take ? diff : s_in;
		end
	end
endmodule
`default_nettype wire

### sv/raru_div.sv
// Restoring divider built from a row of raru_cell, one quotient bit a cycle.
// Depends on raru_pkg and raru_cell.
`timescale 1ns / 1ps
`default_nettype none
module raru_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire raru_pkg::div_req_t req,
	output raru_pkg::div_rsp_t     rsp
);
	logic [raru_pkg::MAG_W-1:0] dvd_q;
	logic [raru_pkg::REM_W-1:0] dsr_q;
	logic [raru_pkg::CNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic [raru_pkg::REM_W-1:0] rem;
	logic [raru_pkg::REM_W:0]   brw;
	logic                        take;

	assign brw[0] = 1'b0;
	assign take   = ~brw[raru_pkg::REM_W];

	// remainder row
	for (genvar i = 0; i < raru_pkg::REM_W; i++) begin : g_cell
		raru_cell u_cell (
			.clk   (clk),
			.clear (req.start),
			.step  (busy_q),
			.s_in  ((i == 0) ? dvd_q[raru_pkg::MAG_W-1] : rem[(i == 0) ? 0 : i-1]),
			.d_bit (dsr_q[i]),
			.b_in  (brw[i]),
			.take  (take),
			.r     (rem[i]),
			.b_out (brw[i+1])
		);
	end

	// shift dividend out, quotient in
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= {1'b0, req.divisor};
		end else if (busy_q) begin
			dvd_q <= {dvd_q[raru_pkg::MAG_W-2:0], take};
		end
	end

	// count steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == raru_pkg::CNT_W'(raru_pkg::MAG_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = busy_q == 1'b0 && cnt_q == raru_pkg::CNT_W'(raru_pkg::MAG_W);
	assign rsp.quot = dvd_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= raru_pkg::CNT_W'(raru_pkg::MAG_W))
		else $error("divider step count past end");
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start |=> (cnt_q != '0))
		else $error("divider count did not advance");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> !busy_q)
		else $error("divider done while busy");
endmodule
`default_nettype wire

### sv/rational_arith_reduce_unit.sv
// Rational add/sub/mul/div and reduce, with reduction to lowest terms.
// A zero numerator or zero denominator goes from the products straight to the
// result; otherwise binary GCD steps (one a cycle) and two bit-serial divides
// by the GCD follow before the result.
// One word at a time; next word taken once the result is in the output register.
// A finished word waits in the output register while the next is taken.
// Reset (arst_n low, asynchronous) empties the unit; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_reduce_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// cmd[2:0], a_num, a_den, b_num, b_den (32 each), zero pad to 136
	input  wire logic [135:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// res_num[31:0], res_den[62:32], zero pad to 64
	output logic [63:0]       m_tdata,
	// status[1:0]
	output logic [1:0]        m_tuser
);
	localparam int W = raru_pkg::OP_W;
	localparam int M = raru_pkg::MAG_W;

	raru_pkg::state_t state_q, state_d;
	raru_pkg::div_req_t dreq;
	raru_pkg::div_rsp_t drsp;

	logic [2:0]   cmd_q;
	logic [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic         ans_q, ads_q, bns_q, bds_q;
	logic [W-1:0] mx, my;
	logic         mxs, mys;
	logic [M-1:0] prod;
	logic [M-1:0] p1_q, p2_q, pd_q;
	logic         p1s_q, p2s_q, pds_q;
	logic [M-1:0] n_mag_q, nq_q;
	logic         neg_q;
	logic [M-1:0] u_q, v_q;
	logic [raru_pkg::K_W-1:0] k_q;
	logic [M-1:0] sum_mag;
	logic         sum_neg;
	logic [M:0]   umv;
	logic [M-1:0] vmu;
	logic         is_red, is_addsub;
	logic [W-1:0] pend_num_q;
	logic [W-2:0] pend_den_q;
	logic [1:0]   pend_st_q;
	logic         ovf;
	logic [W-1:0] m_num_q;
	logic [W-2:0] m_den_q;
	logic [1:0]   m_st_q;
	logic         m_valid_q;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] raw);
		return raw[W-1] ? (~raw + 1'b1) : raw;
	endfunction

	assign is_red    = cmd_q > raru_pkg::CMD_DIV;
	assign is_addsub = cmd_q == raru_pkg::CMD_ADD || cmd_q == raru_pkg::CMD_SUB;

	// pick multiplier operands per phase
	always_comb begin
		mx  = an_q;
		mxs = ans_q;
		my  = bd_q;
		mys = bds_q;
		if (state_q == raru_pkg::ST_MUL_A) begin
			if (is_red) begin
				my  = W'(1);
				mys = 1'b0;
			end else if (cmd_q == raru_pkg::CMD_MUL) begin
				my  = bn_q;
				mys = bns_q;
			end
		end else if (state_q == raru_pkg::ST_MUL_B) begin
			mx  = bn_q;
			mxs = bns_q ^ (cmd_q == raru_pkg::CMD_SUB);
			my  = ad_q;
			mys = ads_q;
		end else begin
			mx  = ad_q;
			mxs = ads_q;
			if (is_red) begin
				my  = W'(1);
				mys = 1'b0;
			end else if (cmd_q == raru_pkg::CMD_DIV) begin
				my  = bn_q;
				mys = bns_q;
			end
		end
	end

	assign prod = M'(mx) * M'(my);

	// signed-magnitude add of the two cross products (add/sub; else first product)
	always_comb begin
		if (!is_addsub) begin
			sum_mag = p1_q;
			sum_neg = p1s_q;
		end else if (p1s_q == p2s_q) begin
			sum_mag = p1_q + p2_q;
			sum_neg = p1s_q;
		end else if (p1_q >= p2_q) begin
			sum_mag = p1_q - p2_q;
			sum_neg = p1s_q;
		end else begin
			sum_mag = p2_q - p1_q;
			sum_neg = p2s_q;
		end
		if (sum_mag == '0) begin
			sum_neg = 1'b0;
		end
	end

	assign umv = {1'b0, u_q} - {1'b0, v_q};
	assign vmu = v_q - u_q;

	// reduced result must fit the operand width
	assign ovf = (drsp.quot[M-1:W-1] != '0)
		|| ((nq_q[M-1:W-1] != '0) && !(neg_q && nq_q == (M'(1) << (W - 1))));

	assign dreq.start    = state_q == raru_pkg::ST_DIVN_GO || state_q == raru_pkg::ST_DIVD_GO;
	assign dreq.dividend = (state_q == raru_pkg::ST_DIVN_GO) ? n_mag_q : pd_q;
	assign dreq.divisor  = u_q << k_q;

	raru_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= raru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			raru_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = raru_pkg::ST_MUL_A;
			end
			raru_pkg::ST_MUL_A: begin
				state_d = is_addsub ? raru_pkg::ST_MUL_B : raru_pkg::ST_MUL_D;
			end
			raru_pkg::ST_MUL_B: state_d = raru_pkg::ST_MUL_D;
			raru_pkg::ST_MUL_D: state_d = raru_pkg::ST_COMB;
			raru_pkg::ST_COMB: begin
				state_d = (pd_q == '0 || sum_mag == '0) ? raru_pkg::ST_FIN : raru_pkg::ST_GCD;
			end
			raru_pkg::ST_GCD: begin
				if (v_q == '0) state_d = raru_pkg::ST_DIVN_GO;
			end
			raru_pkg::ST_DIVN_GO: state_d = raru_pkg::ST_DIVN;
			raru_pkg::ST_DIVN: begin
				if (drsp.done) state_d = raru_pkg::ST_DIVD_GO;
			end
			raru_pkg::ST_DIVD_GO: state_d = raru_pkg::ST_DIVD;
			raru_pkg::ST_DIVD: begin
				if (drsp.done) state_d = raru_pkg::ST_FIN;
			end
			raru_pkg::ST_FIN: begin
				if (!m_valid_q || m_tready) state_d = raru_pkg::ST_IDLE;
			end
			default: state_d = raru_pkg::ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			raru_pkg::ST_IDLE: begin
				cmd_q <= s_tdata[2:0];
				an_q  <= mag_of(s_tdata[34:3]);
				ans_q <= s_tdata[34];
				ad_q  <= mag_of(s_tdata[66:35]);
				ads_q <= s_tdata[66];
				bn_q  <= mag_of(s_tdata[98:67]);
				bns_q <= s_tdata[98];
				bd_q  <= mag_of(s_tdata[130:99]);
				bds_q <= s_tdata[130];
			end
			raru_pkg::ST_MUL_A: begin
				p1_q  <= prod;
				p1s_q <= (prod != '0) && (mxs ^ mys);
			end
			raru_pkg::ST_MUL_B: begin
				p2_q  <= prod;
				p2s_q <= (prod != '0) && (mxs ^ mys);
			end
			raru_pkg::ST_MUL_D: begin
				pd_q  <= prod;
				pds_q <= (prod != '0) && (mxs ^ mys);
			end
			raru_pkg::ST_COMB: begin
				n_mag_q <= sum_mag;
				neg_q   <= sum_neg ^ pds_q;
				u_q     <= sum_mag;
				v_q     <= pd_q;
				k_q     <= '0;
				pend_num_q <= '0;
				pend_den_q <= (pd_q != '0) ? (W-1)'(1) : '0;
				pend_st_q  <= (pd_q == '0) ? raru_pkg::STAT_ZDEN : raru_pkg::STAT_OK;
			end
			raru_pkg::ST_GCD: begin
				// binary GCD, one step a cycle
				if (v_q != '0) begin
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (!umv[M] && umv != '0) begin
						u_q <= v_q;
						v_q <= umv[M-1:0];
					end else begin
						v_q <= vmu;
					end
				end
			end
			raru_pkg::ST_DIVN: begin
				if (drsp.done) nq_q <= drsp.quot;
			end
			raru_pkg::ST_DIVD: begin
				if (drsp.done) begin
					if (ovf) begin
						pend_num_q <= '0;
						pend_den_q <= '0;
						pend_st_q  <= raru_pkg::STAT_OVF;
					end else begin
						pend_num_q <= neg_q ? (~nq_q[W-1:0] + 1'b1) : nq_q[W-1:0];
						pend_den_q <= drsp.quot[W-2:0];
						pend_st_q  <= raru_pkg::STAT_OK;
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == raru_pkg::ST_FIN && (!m_valid_q || m_tready)) begin
			m_num_q <= pend_num_q;
			m_den_q <= pend_den_q;
			m_st_q  <= pend_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == raru_pkg::ST_FIN && (!m_valid_q || m_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_den_q, m_num_q};
	assign m_tuser  = m_st_q;

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |=> !drsp.done)
		else $error("divider done right after start");
	a_gcd_u: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == raru_pkg::ST_GCD |-> u_q != '0)
		else $error("GCD operand became zero");
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == raru_pkg::STAT_OK |-> m_tdata[62:32] != '0)
		else $error("ok result with zero denominator");
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for rational_arith_reduce_unit: drives fraction pairs and commands,
// predicts reduced results and status, and checks each output word in order.
// Depends on raru_pkg and the rational_arith_reduce_unit RTL.
`timescale 1ns / 1ps
`default_nettype none

class frac_scoreboard;
	logic [31:0] num_q[$];
	logic [30:0] den_q[$];
	logic [1:0]  stat_q[$];
	int          errors;

	// magnitude of a 32-bit two's-complement operand
	static function logic [63:0] mag_of(logic [31:0] v);
		return v[31] ? {32'd0, -v} : {32'd0, v};
	endfunction

	// note one accepted input word and queue its expected result
	function void note_input(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		logic [63:0] nm, dm, p, q, x, y, t, lim;
		logic        nneg, dneg, pneg, qneg, bneg, neg;
		lim  = 64'h8000_0000;
		bneg = bn[31];
		if (cmd == raru_pkg::CMD_SUB && bn != 0)
			bneg = !bneg;
		case (cmd)
			raru_pkg::CMD_ADD, raru_pkg::CMD_SUB: begin
				p = mag_of(an) * mag_of(bd);
				pneg = (p != 0) && (an[31] != bd[31]);
				q = mag_of(bn) * mag_of(ad);
				qneg = (q != 0) && (bneg != ad[31]);
				if (pneg == qneg) begin
					nm = p + q; nneg = pneg;
				end else if (p >= q) begin
					nm = p - q; nneg = pneg;
				end else begin
					nm = q - p; nneg = qneg;
				end
				dm = mag_of(ad) * mag_of(bd);
				dneg = ad[31] != bd[31];
			end
			raru_pkg::CMD_MUL: begin
				nm = mag_of(an) * mag_of(bn); nneg = an[31] != bn[31];
				dm = mag_of(ad) * mag_of(bd); dneg = ad[31] != bd[31];
			end
			raru_pkg::CMD_DIV: begin
				nm = mag_of(an) * mag_of(bd); nneg = an[31] != bd[31];
				dm = mag_of(ad) * mag_of(bn); dneg = ad[31] != bn[31];
			end
			default: begin
				nm = mag_of(an); nneg = an[31];
				dm = mag_of(ad); dneg = ad[31];
			end
		endcase
		if (dm == 0) begin
			push(0, 0, raru_pkg::STAT_ZDEN);
		end else if (nm == 0) begin
			push(0, 1, raru_pkg::STAT_OK);
		end else begin
			x = nm; y = dm;
			while (y != 0) begin
				t = x % y; x = y; y = t;
			end
			nm = nm / x; dm = dm / x;
			neg = nneg != dneg;
			if (dm > lim - 1 || nm > (neg ? lim : lim - 1))
				push(0, 0, raru_pkg::STAT_OVF);
			else
				push(neg ? -nm[31:0] : nm[31:0], dm[30:0], raru_pkg::STAT_OK);
		end
	endfunction

	function void push(logic [31:0] n, logic [30:0] d, logic [1:0] s);
		num_q.push_back(n); den_q.push_back(d); stat_q.push_back(s);
	endfunction

	// compare one output word with the oldest expectation
	function void check_result(logic [31:0] n, logic [30:0] d, logic [1:0] s);
		logic [31:0] en;
		logic [30:0] ed;
		logic [1:0]  es;
		if (num_q.size() == 0) begin
			$error("unexpected result word num=%h den=%h status=%0d", n, d, s);
			errors++;
			return;
		end
		en = num_q.pop_front(); ed = den_q.pop_front(); es = stat_q.pop_front();
		if (n !== en) begin
			$error("res_num expected %h actual %h", en, n); errors++;
		end
		if (d !== ed) begin
			$error("res_den expected %h actual %h", ed, d); errors++;
		end
		if (s !== es) begin
			$error("status expected %0d actual %0d", es, s); errors++;
		end
	endfunction

	function int pending();
		return num_q.size();
	endfunction
endclass

module tb_top;
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;

	frac_scoreboard frac_sb;
	bit             long_hold;
	int             sent;

	rational_arith_reduce_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		#20000000;
		$display("rational_arith_reduce_unit verification failed");
		$finish;
	end

	// check words accepted by the receiver and note words accepted by the block
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			frac_sb.check_result(m_tdata[31:0], m_tdata[62:32], m_tuser);
		if (arst_n && s_tvalid && s_tready)
			frac_sb.note_input(s_tdata[2:0], s_tdata[34:3], s_tdata[66:35],
				s_tdata[98:67], s_tdata[130:99]);
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int cyc;
		m_tready = 1'b0;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (long_hold)
				m_tready <= 1'b0;
			else if ((cyc / 64) % 3 == 0)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		@(posedge clk);
		wait (sent >= 300);
		long_hold = 1'b1;
		repeat (3000) @(posedge clk);
		long_hold = 1'b0;
	end

	// offer one word and hold it until accepted
	task automatic send_word(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, bd, bn, ad, an, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 15);
			1: return -$urandom_range(1, 15);
			2: return $urandom;
			3: return $urandom & 32'h0000_ffff;
			4: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff)
				^ $urandom_range(0, 3);
			default: return $urandom_range(1, 1000) * $urandom_range(1, 1000);
		endcase
	endfunction

	initial begin
		logic [31:0] g;
		logic [2:0]  cmd;
		int          burst;
		frac_sb  = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each operation, extremes, zero denominators, overflow, codes 5..7
		send_word(raru_pkg::CMD_ADD, 1, 2, 1, 3);
		send_word(raru_pkg::CMD_SUB, 1, 2, 1, 2);
		send_word(raru_pkg::CMD_MUL, -2, 3, 3, -4);
		send_word(raru_pkg::CMD_DIV, 1, 2, 0, 5);
		send_word(raru_pkg::CMD_DIV, 3, -4, -6, 8);
		send_word(raru_pkg::CMD_RED, 6, -8, 0, 0);
		send_word(3'd5, 0, 7, 1, 1);
		send_word(3'd6, 5, 0, 1, 1);
		send_word(3'd7, 32'h8000_0000, 1, 9, 9);
		send_word(raru_pkg::CMD_RED, 32'h8000_0000, -1, 0, 0);
		send_word(raru_pkg::CMD_RED, 1, 32'h8000_0000, 0, 0);
		send_word(raru_pkg::CMD_RED, 2, 32'h8000_0000, 0, 0);
		send_word(raru_pkg::CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
		send_word(raru_pkg::CMD_SUB, 32'h8000_0000, 1, 1, 1);
		send_word(raru_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000);
		send_word(raru_pkg::CMD_MUL, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000);
		send_word(raru_pkg::CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
		send_word(raru_pkg::CMD_DIV, 32'h7fff_ffff, 3, 32'h7fff_fffe, 5);
		send_word(raru_pkg::CMD_SUB, 0, 3, 0, -7);
		send_word(raru_pkg::CMD_ADD, 32'hffff_ffff, 32'h7fff_ffff, 1, 32'h7fff_ffff);
		send_word(raru_pkg::CMD_DIV, 0, 5, 0, 6);

		// random: mostly valid fractions sharing factors, some raw noise
		while (sent < 1850) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				cmd = 3'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
					: $urandom_range(0, 4));
				if ($urandom_range(0, 3) == 0) begin
					send_word(cmd, $urandom, $urandom, $urandom, $urandom);
				end else begin
					g = $urandom_range(1, 50);
					send_word(cmd, rand_val() * g, rand_val() * g,
						rand_val(), ($urandom_range(0, 20) == 0) ? 0 : rand_val());
				end
			end
			idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40));
		end
		s_tvalid <= 1'b0;

		// drain, then settle
		while (frac_sb.pending() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (frac_sb.errors == 0 && frac_sb.pending() == 0)
			$display("rational_arith_reduce_unit verification clean");
		else
			$display("rational_arith_reduce_unit verification failed");
		$finish;
	end
endmodule
`default_nettype wire
